// ----- sv/sawr_pkg.sv -----
// ----------------------------------------------------------------------------
// sawr_pkg: shared types and constants of the stop-and-wait ARQ receiver.
// Holds the byte width, the sequence bias and the field codes used by the
// receiver and its payload memory.
// ----------------------------------------------------------------------------
package sawr_pkg;

    // Width of one packet byte.
    localparam int BYTE_W = 8;

    // Default packet length in bytes, including the three trailer bytes.
    localparam int PACKET_BYTES_DEF = 16;

    // Number of trailer bytes: sequence, type and checksum.
    localparam int TRAILER_BYTES = 3;

    // Bias applied to sequence numbers on the wire.
    localparam logic [BYTE_W-1:0] SEQ_BIAS = 8'h80;

    // Reset value of the acknowledgement type register.
    localparam logic [BYTE_W-1:0] ACK_TYPE_RESET = 8'h01;

    // Input transaction kinds.
    typedef enum logic {
        MODE_BYTE  = 1'b0,
        MODE_CLEAR = 1'b1
    } mode_t;

    // Result kinds.
    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_ACK     = 1'b1
    } kind_t;

    // Packet verdicts carried by an acknowledgement.
    typedef enum logic [1:0] {
        VERDICT_ACCEPTED = 2'd0,
        VERDICT_CORRUPT  = 2'd1,
        VERDICT_BAD_SEQ  = 2'd2
    } verdict_t;

endpackage

// ----- sv/sawr_payload_ram.sv -----
// ----------------------------------------------------------------------------
// sawr_payload_ram: payload byte store of the receiver.
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module sawr_payload_ram
    import sawr_pkg::*;
#(
    parameter int DEPTH  = PACKET_BYTES_DEF - TRAILER_BYTES,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/stop_and_wait_arq_receiver.sv -----
// ----------------------------------------------------------------------------
// stop_and_wait_arq_receiver: receiver side of a stop-and-wait ARQ link.
// Packets of PACKET_BYTES bytes arrive one byte per transaction: payload, then
// a sequence byte, a type byte and a checksum byte. Payload bytes are written
// into a small synchronous memory. The checksum byte closes the packet: if the
// checksum is the NOT of the byte sum and the unbiased sequence number is one
// more than the last accepted one, the payload is read back from memory and
// delivered up to the first zero byte, each byte by a read issue followed by
// the registered read data, and the sequence counter advances. Every packet
// then ends with one acknowledgement transaction with m_tlast high. After the
// input bytes of a packet comes a drain during which s_tready stays low; for
// an accepted packet a zero byte that ends delivery is still fetched and
// inspected. Stalls on m_tready lengthen the drain. The registered read of the
// payload store sets the drain rate. A transaction with s_tuser high clears
// the session and yields no result.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_receiver
    import sawr_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration: acknowledgement type code.
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    // Input stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] packet_byte
    input  logic              s_tuser,   // [0] mode
    // Result stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // [7:0] payload_out, [15:8] ack_seq_byte,
                                         // [23:16] ack_type_byte,
                                         // [31:24] ack_check_byte,
                                         // [33:32] verdict, [39:34] zero
    output logic              m_tuser,   // [0] result_kind
    output logic              m_tlast    // last_of_run
);

    localparam int PAYLOAD_BYTES = PACKET_BYTES - TRAILER_BYTES;
    localparam int POS_W  = $clog2(PACKET_BYTES);
    localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CNT_W  = $clog2(PAYLOAD_BYTES + 1);

    typedef enum logic [3:0] {
        ST_RECV  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_PAY   = 4'b0100,
        ST_ACK   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] rseq_reg, rseq_next;
    logic [BYTE_W-1:0] last_seq_reg, last_seq_next;
    verdict_t          verdict_reg, verdict_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] ack_type_reg;

    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0] out_pay_reg, out_pay_next;
    logic [BYTE_W-1:0] out_seq_reg, out_seq_next;
    logic [BYTE_W-1:0] out_type_reg, out_type_next;
    logic [BYTE_W-1:0] out_chk_reg, out_chk_next;
    verdict_t          out_verd_reg, out_verd_next;
    logic              out_last_reg, out_last_next;

    logic              in_fire;
    logic              out_free;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic              mem_rd_en;
    logic [BYTE_W-1:0] mem_rd_data;
    logic [BYTE_W-1:0] ack_seq;
    logic [BYTE_W-1:0] want_seq;

    assign s_tready = (state_reg == ST_RECV);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign want_seq = last_seq_reg + 8'd1;
    assign ack_seq  = last_seq_reg ^ SEQ_BIAS;

    // Payload memory: written while a packet streams in, read while it drains,
    // so the two ports never touch the same entry in the same cycle.
    assign mem_wr_en   = in_fire && (s_tuser == MODE_BYTE)
                         && (pos_reg < POS_W'(PAYLOAD_BYTES));
    assign mem_wr_addr = pos_reg[ADDR_W-1:0];
    assign mem_rd_en   = (state_reg == ST_FETCH) && (idx_reg != CNT_W'(PAYLOAD_BYTES));

    sawr_payload_ram #(
        .DEPTH  (PAYLOAD_BYTES),
        .ADDR_W (ADDR_W)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (s_tdata),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    // Packet state machine and result register loading.
    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        rseq_next      = rseq_reg;
        last_seq_next  = last_seq_reg;
        verdict_next   = verdict_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_pay_next   = out_pay_reg;
        out_seq_next   = out_seq_reg;
        out_type_next  = out_type_reg;
        out_chk_next   = out_chk_reg;
        out_verd_next  = out_verd_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_RECV: begin
                if (in_fire) begin
                    if (s_tuser == MODE_CLEAR) begin
                        last_seq_next = '0;
                        pos_next      = '0;
                        sum_next      = '0;
                    end else if (pos_reg != POS_W'(PACKET_BYTES - 1)) begin
                        if (pos_reg == POS_W'(PAYLOAD_BYTES)) begin
                            rseq_next = s_tdata;
                        end
                        sum_next = sum_reg + s_tdata;
                        pos_next = pos_reg + 1'b1;
                    end else begin
                        // Checksum byte: judge the packet.
                        pos_next = '0;
                        sum_next = '0;
                        idx_next = '0;
                        if (s_tdata != ~sum_reg) begin
                            verdict_next = VERDICT_CORRUPT;
                            state_next   = ST_ACK;
                        end else if ((rseq_reg ^ SEQ_BIAS) != want_seq) begin
                            verdict_next = VERDICT_BAD_SEQ;
                            state_next   = ST_ACK;
                        end else begin
                            verdict_next  = VERDICT_ACCEPTED;
                            last_seq_next = want_seq;
                            state_next    = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH: begin
                // Issue the read of the next payload byte, or stop at the end.
                if (idx_reg == CNT_W'(PAYLOAD_BYTES)) begin
                    state_next = ST_ACK;
                end else begin
                    state_next = ST_PAY;
                end
            end
            ST_PAY: begin
                // Read data is valid; a zero byte ends delivery.
                if (mem_rd_data == '0) begin
                    state_next = ST_ACK;
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PAYLOAD;
                    out_pay_next   = mem_rd_data;
                    out_seq_next   = '0;
                    out_type_next  = '0;
                    out_chk_next   = '0;
                    out_verd_next  = VERDICT_ACCEPTED;
                    out_last_next  = 1'b0;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = ST_FETCH;
                end
            end
            ST_ACK: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ACK;
                    out_pay_next   = '0;
                    out_seq_next   = ack_seq;
                    out_type_next  = ack_type_reg;
                    out_chk_next   = ~(ack_seq + ack_type_reg);
                    out_verd_next  = verdict_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_RECV;
                end
            end
            default: begin
                state_next = ST_RECV;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RECV;
            pos_reg       <= '0;
            sum_reg       <= '0;
            rseq_reg      <= '0;
            last_seq_reg  <= '0;
            verdict_reg   <= VERDICT_ACCEPTED;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            rseq_reg      <= rseq_next;
            last_seq_reg  <= last_seq_next;
            verdict_reg   <= verdict_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_type_reg <= ACK_TYPE_RESET;
        end else if (cfg_wr_en) begin
            ack_type_reg <= cfg_wr_data;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_pay_reg  <= out_pay_next;
        out_seq_reg  <= out_seq_next;
        out_type_reg <= out_type_next;
        out_chk_reg  <= out_chk_next;
        out_verd_reg <= out_verd_next;
        out_last_reg <= out_last_next;
    end

    // Result stream outputs.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_verd_reg, out_chk_reg, out_type_reg,
                       out_seq_reg, out_pay_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the stop-and-wait ARQ receiver.
// Packets are fed one byte per transaction. A scoreboard class predicts every
// delivered payload byte and every acknowledgement from the bytes the block
// has taken, then checks the result stream in order. The run covers directed
// packets, a run of clean packets right after a session clear, and random
// traffic under varying sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import sawr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PKT            = PACKET_BYTES_DEF;
    localparam int PAYLOAD        = PKT - TRAILER_BYTES;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    // One result of the block, as it appears on the result stream.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload;
        logic [7:0] seq_b;
        logic [7:0] type_b;
        logic [7:0] check_b;
        verdict_t   verdict;
        logic       last;
    } delivery_t;

    // Ways a generated packet can be built.
    typedef enum {
        PK_GOOD,
        PK_CORRUPT,
        PK_STALE,
        PK_CUT,
        PK_NOISE
    } pk_flavor_t;

    // Scoreboard: tracks the receiver state and holds the results still due.
    class arq_tracker;
        logic [7:0]  ack_type;
        int unsigned pos;
        logic [7:0]  sum;
        logic [7:0]  store [PAYLOAD];
        logic [7:0]  rx_seq;
        logic [7:0]  last_seq;
        delivery_t   due [$];
        int          errors;

        function new();
            ack_type = ACK_TYPE_RESET;
            pos      = 0;
            sum      = '0;
            rx_seq   = '0;
            last_seq = '0;
            errors   = 0;
        endfunction

        function string show(delivery_t d);
            return $sformatf({"kind=%0d pay=%02h seq=%02h type=%02h chk=%02h ",
                              "verdict=%0d last=%0b"},
                             d.kind, d.payload, d.seq_b, d.type_b, d.check_b, d.verdict,
                             d.last);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("tb: mismatch: %s", msg);
            end
        endfunction

        // Account for one accepted input transaction.
        function void take_byte(mode_t md, logic [7:0] b);
            delivery_t  d;
            logic [7:0] want_seq;
            logic [7:0] seq_b;
            logic [7:0] sum_ck;
            verdict_t   v;
            int         i;
            if (md == MODE_CLEAR) begin
                last_seq = '0;
                pos      = 0;
                sum      = '0;
                return;
            end
            if (pos < PKT - 1) begin
                if (pos < PAYLOAD) begin
                    store[pos] = b;
                end else if (pos == PAYLOAD) begin
                    rx_seq = b;
                end
                sum = sum + b;
                pos++;
                return;
            end
            // Checksum byte: judge the packet.
            want_seq = last_seq + 8'd1;
            sum_ck   = ~sum;
            if (b != sum_ck) begin
                v = VERDICT_CORRUPT;
            end else if ((rx_seq ^ SEQ_BIAS) != want_seq) begin
                v = VERDICT_BAD_SEQ;
            end else begin
                v = VERDICT_ACCEPTED;
                for (i = 0; i < PAYLOAD && store[i] != 8'h00; i++) begin
                    d         = '0;
                    d.kind    = KIND_PAYLOAD;
                    d.payload = store[i];
                    due = {due, d};
                end
                last_seq = want_seq;
            end
            seq_b     = last_seq ^ SEQ_BIAS;
            d         = '0;
            d.kind    = KIND_ACK;
            d.seq_b   = seq_b;
            d.type_b  = ack_type;
            d.check_b = ~(seq_b + ack_type);
            d.verdict = v;
            d.last    = 1'b1;
            due = {due, d};
            pos = 0;
            sum = '0;
        endfunction

        // Compare one accepted result with the oldest one due.
        function void check_result(logic kind, logic [39:0] data, logic last);
            delivery_t seen;
            delivery_t want;
            seen.kind    = kind_t'(kind);
            seen.payload = data[7:0];
            seen.seq_b   = data[15:8];
            seen.type_b  = data[23:16];
            seen.check_b = data[31:24];
            seen.verdict = verdict_t'(data[33:32]);
            seen.last    = last;
            if (due.size() == 0) begin
                flag({"result with nothing due: ", show(seen)});
                return;
            end
            want = due.pop_front();
            if (seen !== want) begin
                flag({"expected ", show(want), " got ", show(seen)});
            end
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        s_tuser     = MODE_BYTE;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    arq_tracker  sb;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int          items_sent   = 0;
    logic        hold_go      = 1'b0;

    stop_and_wait_arq_receiver #(
        .PACKET_BYTES(PKT)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Offer one input transaction and wait until the block takes it.
    task automatic send_item(input mode_t md, input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.take_byte(md, b);
        items_sent++;
        @(negedge aclk);
    endtask

    // Build one packet of the given flavor and send it byte by byte.
    // Payload bytes before zero_at are nonzero; a nonzero fill replaces them
    // and the type byte with a fixed value.
    task automatic send_packet(input pk_flavor_t fl, input int zero_at, input logic [7:0] fill);
        logic [7:0] pkt [PKT];
        logic [7:0] total;
        int         i;
        int         cut_at;
        total = '0;
        for (i = 0; i < PAYLOAD; i++) begin
            if (i < zero_at) begin
                pkt[i] = (fill != 8'h00) ? fill : 8'($urandom_range(1, 255));
            end else if (i == zero_at) begin
                pkt[i] = 8'h00;
            end else begin
                pkt[i] = 8'($urandom_range(0, 255));
            end
        end
        pkt[PAYLOAD] = (sb.last_seq + 8'd1) ^ SEQ_BIAS;
        if (fl == PK_STALE) begin
            // Either a retransmission of the last number or some other wrong one.
            pkt[PAYLOAD] = ($urandom_range(1) == 0) ? (sb.last_seq ^ SEQ_BIAS)
                                                    : (pkt[PAYLOAD] ^ 8'($urandom_range(1, 255)));
        end
        pkt[PAYLOAD+1] = (fill != 8'h00) ? fill : 8'($urandom_range(0, 255));
        for (i = 0; i < PKT - 1; i++) begin
            total = total + pkt[i];
        end
        pkt[PKT-1] = ~total;
        if (fl == PK_CORRUPT) begin
            pkt[PKT-1] = pkt[PKT-1] ^ 8'($urandom_range(1, 255));
        end
        if (fl == PK_NOISE) begin
            for (i = 0; i < PKT; i++) begin
                pkt[i] = 8'($urandom_range(0, 255));
            end
        end
        cut_at = (fl == PK_CUT) ? $urandom_range(0, PKT - 1) : PKT;
        for (i = 0; i < cut_at; i++) begin
            send_item(MODE_BYTE, pkt[i]);
        end
        if (fl == PK_CUT) begin
            send_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly clean packets, with corrupt, out-of-order, cut and noise ones mixed in.
    task automatic run_random(input int n);
        int          first;
        int unsigned pick;
        pk_flavor_t  fl;
        first = items_sent;
        while (items_sent - first < n) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                fl = PK_GOOD;
            end else if (pick < 80) begin
                fl = PK_CORRUPT;
            end else if (pick < 88) begin
                fl = PK_STALE;
            end else if (pick < 94) begin
                fl = PK_CUT;
            end else begin
                fl = PK_NOISE;
            end
            send_packet(fl, $urandom_range(0, PAYLOAD), 8'h00);
        end
    endtask

    // Stop offering input and wait until every due result has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_ack_type(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.ack_type = v;
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_go) begin
                hold_go = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result monitor.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_result(m_tuser, m_tdata, m_tlast);
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin
        sb = new;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed packets with the reset type code: full 0xFF payload, empty
        // payload, bad checksum, wrong sequence number, cut packet, clear when idle.
        send_packet(PK_GOOD, PAYLOAD, 8'hFF);
        send_packet(PK_GOOD, 0, 8'h01);
        send_packet(PK_CORRUPT, 5, 8'h00);
        send_packet(PK_STALE, 3, 8'h00);
        send_packet(PK_CUT, 4, 8'h00);
        send_item(MODE_CLEAR, 8'hFF);
        send_packet(PK_GOOD, 7, 8'h80);
        settle();

        // Clean packets right after a session clear, all-ones type code.
        write_ack_type(8'hFF);
        send_item(MODE_CLEAR, 8'h00);
        repeat (4) send_packet(PK_GOOD, $urandom_range(0, 2), 8'h00);
        settle();

        // Random traffic, no idling, with one long receiver hold-off.
        write_ack_type(8'h00);
        run_random(20);
        hold_go = 1'b1;
        repeat (3) send_packet(PK_GOOD, PAYLOAD, 8'h00);
        run_random(16);
        settle();

        // Sender gaps.
        write_ack_type(8'($urandom_range(0, 255)));
        tx_idle_pct  = 52;
        rx_stall_pct = 0;
        run_random(50);
        settle();

        // Receiver stalls.
        write_ack_type(8'h80);
        tx_idle_pct  = 0;
        rx_stall_pct = 52;
        run_random(50);
        settle();

        // Both sides idling.
        write_ack_type(8'($urandom_range(0, 255)));
        tx_idle_pct  = 22;
        rx_stall_pct = 22;
        run_random(50);
        settle();

        if (sb.errors == 0 && sb.due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
